// ===== hdl/ptom_pkg.sv =====
// Shared types, constants and codes of the price-time order matcher.
package ptom_pkg;

  localparam int unsigned BookDepth  = 32;
  localparam int unsigned MaxResults = 64;
  localparam int unsigned KW         = $clog2(MaxResults + 1);

  localparam logic KindTrade  = 1'b0;
  localparam logic KindReject = 1'b1;
  localparam logic SideBuy    = 1'b1;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] qty;
    logic [15:0] price;
  } entry_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] buy_id;
    logic [31:0] sell_id;
    logic [15:0] qty;
    logic [15:0] price;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REJ,
    S_INS_RD,
    S_INS_CMP,
    S_M_RD,
    S_M_CMP,
    S_FLUSH
  } state_e;

endpackage

// ===== hdl/ptom_ram.sv =====
// One book side: simple dual-port memory with registered read data.
module ptom_ram #(
  parameter int unsigned Depth = ptom_pkg::BookDepth,
  parameter int unsigned AW    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  ptom_pkg::entry_t wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output ptom_pkg::entry_t rdata_o
);
  import ptom_pkg::*;

  entry_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/price_time_order_matcher.sv =====
// Top level of the price-time priority order matcher.
// Each book side is a ring buffer in its own memory; a small sequencer with one
// compare/subtract path inserts an order by walking from the tail toward the
// head: each queued order that ranks behind the new one is read, compared and
// moved one place toward the tail, and the new order is written into the gap,
// at the head when it ranks first. Matching reads both heads, then compares and
// updates them, holding while the result cannot be pushed; the final result
// leaves one result later since the last flag is known only at the end of the
// run. Input is not ready until all results of the current order are handed
// to the output register. No clearing pass: entries past the count are unread.
module price_time_order_matcher #(
  parameter int unsigned BookDepth = ptom_pkg::BookDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // order_id[31:0], limit_price[47:32], quantity[63:48]
  input  logic [63:0]   s_axis_tdata_i,
  // side
  input  logic          s_axis_tuser_i,
  // end_of_batch
  input  logic          s_axis_tlast_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // buy_order_id[31:0], sell_order_id[63:32], trade_quantity[79:64], trade_price[95:80]
  output logic [95:0]   m_axis_tdata_o,
  // kind
  output logic          m_axis_tuser_o,
  // last
  output logic          m_axis_tlast_o
);
  import ptom_pkg::*;

  localparam int unsigned IW = $clog2(BookDepth);
  localparam int unsigned CW = $clog2(BookDepth + 1);

  state_e          state_q, state_d;
  logic [31:0]     id_q, id_d;
  logic            side_q, side_d;
  logic [15:0]     price_q, price_d;
  logic [15:0]     qty_q, qty_d;
  logic            eob_q, eob_d;
  logic [CW-1:0]   j_q, j_d;
  logic [IW-1:0]   bhead_q, bhead_d, shead_q, shead_d;
  logic [CW-1:0]   bcnt_q, bcnt_d, scnt_q, scnt_d;
  logic [KW-1:0]   k_q, k_d;
  logic            pend_v_q, pend_v_d;
  result_t         pend_q, pend_d;
  logic            out_v_q, out_v_d;
  logic            out_last_q, out_last_d;
  result_t         out_q, out_d;

  logic            b_we, s_we;
  logic [IW-1:0]   b_waddr, s_waddr, b_raddr, s_raddr;
  entry_t          b_wdata, s_wdata, b_rdata, s_rdata;

  function automatic logic [IW-1:0] phys(input logic [IW-1:0] head,
                                         input logic [IW-1:0] rel);
    logic [IW:0] sum;
    sum = {1'b0, head} + {1'b0, rel};
    if (sum >= (IW+1)'(BookDepth)) begin
      sum = sum - (IW+1)'(BookDepth);
    end
    return sum[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] inc(input logic [IW-1:0] a);
    return (a == IW'(BookDepth - 1)) ? '0 : a + 1'b1;
  endfunction

  ptom_ram #(.Depth(BookDepth), .AW(IW)) u_buy (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i(b_wdata),
    .raddr_i(b_raddr), .rdata_o(b_rdata)
  );
  ptom_ram #(.Depth(BookDepth), .AW(IW)) u_sell (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  // shared compare/subtract path
  entry_t        cur;
  logic          move;
  logic          crossed;
  logic [15:0]   tq, bq_new, sq_new;
  logic          out_free, in_acc, can_push, full_side;
  entry_t        new_ent;
  logic [IW-1:0] ins_head;

  assign cur      = side_q ? b_rdata : s_rdata;
  assign move     = side_q ? (cur.price < price_q) : (cur.price > price_q);
  assign crossed  = b_rdata.price >= s_rdata.price;
  assign tq       = (b_rdata.qty < s_rdata.qty) ? b_rdata.qty : s_rdata.qty;
  assign bq_new   = b_rdata.qty - tq;
  assign sq_new   = s_rdata.qty - tq;
  assign out_free = !out_v_q || m_axis_tready_i;
  assign can_push = !pend_v_q || out_free;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign new_ent  = '{id: id_q, qty: qty_q, price: price_q};
  assign ins_head = side_q ? bhead_q : shead_q;
  assign full_side = (s_axis_tuser_i ? bcnt_q : scnt_q) == CW'(BookDepth);

  assign s_axis_tready_o = (state_q == S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (s_axis_tdata_i[63:48] == '0 || full_side) ? S_REJ : S_INS_RD;
        end
      end
      S_REJ:     state_d = eob_q ? S_M_RD : S_FLUSH;
      S_INS_RD: begin
        if (j_q == '0) state_d = eob_q ? S_M_RD : S_FLUSH;
        else           state_d = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (move) state_d = S_INS_RD;
        else      state_d = eob_q ? S_M_RD : S_FLUSH;
      end
      S_M_RD: begin
        if (k_q == KW'(MaxResults) || bcnt_q == '0 || scnt_q == '0) state_d = S_FLUSH;
        else state_d = S_M_CMP;
      end
      S_M_CMP: begin
        if (!crossed)      state_d = S_FLUSH;
        else if (can_push) state_d = S_M_RD;
      end
      S_FLUSH: begin
        if (!pend_v_q || out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    id_d = id_q; side_d = side_q; price_d = price_q; qty_d = qty_q; eob_d = eob_q;
    j_d = j_q; bhead_d = bhead_q; shead_d = shead_q; bcnt_d = bcnt_q; scnt_d = scnt_q;
    k_d = k_q; pend_v_d = pend_v_q; pend_d = pend_q;
    out_d = out_q; out_last_d = out_last_q;
    out_v_d = out_v_q && !m_axis_tready_i;
    b_we = 1'b0; s_we = 1'b0;
    b_waddr = bhead_q; s_waddr = shead_q;
    b_wdata = new_ent; s_wdata = new_ent;
    b_raddr = bhead_q; s_raddr = shead_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          id_d    = s_axis_tdata_i[31:0];
          price_d = s_axis_tdata_i[47:32];
          qty_d   = s_axis_tdata_i[63:48];
          side_d  = s_axis_tuser_i;
          eob_d   = s_axis_tlast_i;
          j_d     = s_axis_tuser_i ? bcnt_q : scnt_q;
          k_d     = '0;
        end
      end
      S_REJ: begin
        pend_v_d = 1'b1;
        pend_d   = '{kind: KindReject, buy_id: side_q ? id_q : '0,
                     sell_id: side_q ? '0 : id_q, qty: '0, price: '0};
        k_d      = KW'(1);
      end
      S_INS_RD: begin
        b_raddr = phys(bhead_q, IW'(j_q - 1'b1));
        s_raddr = phys(shead_q, IW'(j_q - 1'b1));
        if (j_q == '0) begin
          // insert at the head
          if (side_q == SideBuy) begin
            b_we = 1'b1; bcnt_d = bcnt_q + 1'b1;
          end else begin
            s_we = 1'b1; scnt_d = scnt_q + 1'b1;
          end
        end
      end
      S_INS_CMP: begin
        b_waddr = phys(ins_head, j_q[IW-1:0]);
        s_waddr = b_waddr;
        if (move) begin
          // shift one entry toward the tail
          b_wdata = cur; s_wdata = cur;
          j_d = j_q - 1'b1;
        end else if (side_q == SideBuy) begin
          bcnt_d = bcnt_q + 1'b1;
        end else begin
          scnt_d = scnt_q + 1'b1;
        end
        b_we = (side_q == SideBuy);
        s_we = (side_q != SideBuy);
      end
      S_M_CMP: begin
        if (crossed && can_push) begin
          if (pend_v_q) begin
            out_v_d = 1'b1; out_d = pend_q; out_last_d = 1'b0;
          end
          pend_v_d = 1'b1;
          pend_d   = '{kind: KindTrade, buy_id: b_rdata.id, sell_id: s_rdata.id,
                       qty: tq, price: s_rdata.price};
          k_d      = k_q + 1'b1;
          b_wdata  = '{id: b_rdata.id, qty: bq_new, price: b_rdata.price};
          s_wdata  = '{id: s_rdata.id, qty: sq_new, price: s_rdata.price};
          if (bq_new == '0) begin
            bhead_d = inc(bhead_q); bcnt_d = bcnt_q - 1'b1;
          end else begin
            b_we = 1'b1;
          end
          if (sq_new == '0) begin
            shead_d = inc(shead_q); scnt_d = scnt_q - 1'b1;
          end else begin
            s_we = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (pend_v_q && out_free) begin
          out_v_d = 1'b1; out_d = pend_q; out_last_d = 1'b1;
          pend_v_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      bhead_q  <= '0;
      shead_q  <= '0;
      bcnt_q   <= '0;
      scnt_q   <= '0;
      k_q      <= '0;
      j_q      <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      bhead_q  <= bhead_d;
      shead_q  <= shead_d;
      bcnt_q   <= bcnt_d;
      scnt_q   <= scnt_d;
      k_q      <= k_d;
      j_q      <= j_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    side_q     <= side_d;
    price_q    <= price_d;
    qty_q      <= qty_d;
    eob_q      <= eob_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_q.price, out_q.qty, out_q.sell_id, out_q.buy_id};
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_last_q;

  a_bcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q <= CW'(BookDepth)) else $error("buy count over depth");
  a_scnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scnt_q <= CW'(BookDepth)) else $error("sell count over depth");
  a_trade_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_M_CMP && crossed && can_push) |-> k_q < KW'(MaxResults))
    else $error("result limit exceeded");
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_v_q) else $error("pending result left in idle");

endmodule

// ===== test/tb_price_time_order_matcher.sv =====
// Self-checking testbench for the price-time order matcher: directed and random orders.
module tb_price_time_order_matcher;
  import ptom_pkg::*;

  localparam int Depth = BookDepth;
  localparam int IdleLimit = 20000;

  typedef struct packed {
    logic [31:0] id;
    logic        side;
    logic [15:0] price;
    logic [15:0] qty;
    logic        eob;
  } order_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] bid;
    logic [31:0] sid;
    logic [15:0] qty;
    logic [15:0] price;
    logic        last;
  } fill_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic        s_ready;
  logic [63:0] s_data;
  logic        s_user;
  logic        s_last;
  logic        m_valid;
  logic        m_ready;
  logic [95:0] m_data;
  logic        m_user;
  logic        m_last;

  price_time_order_matcher dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  // Book copies kept by the predictor.
  entry_t bids_q[$];
  entry_t asks_q[$];
  order_t pending_q[$];
  fill_t  fills_q[$];
  int     errors;
  int     idle_cycles;
  bit     stim_done;
  int     burst_left;
  int     gap_left;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void book_order(order_t o);
    entry_t e;
    int     pos;
    int     k;
    fill_t  f;
    int     n;
    logic [15:0] tq;
    n = 0;
    e.id = o.id; e.qty = o.qty; e.price = o.price;
    if (o.qty == 0 || (o.side == SideBuy ? bids_q.size() : asks_q.size()) >= Depth) begin
      f = '0;
      f.kind = KindReject;
      if (o.side == SideBuy) f.bid = o.id; else f.sid = o.id;
      fills_q.insert(fills_q.size(), f);
      n++;
    end else if (o.side == SideBuy) begin
      pos = bids_q.size();
      for (k = 0; k < bids_q.size(); k++)
        if (bids_q[k].price < o.price) begin pos = k; break; end
      bids_q.insert(pos, e);
    end else begin
      pos = asks_q.size();
      for (k = 0; k < asks_q.size(); k++)
        if (asks_q[k].price > o.price) begin pos = k; break; end
      asks_q.insert(pos, e);
    end
    if (o.eob) begin
      while (n < MaxResults && bids_q.size() > 0 && asks_q.size() > 0 &&
             bids_q[0].price >= asks_q[0].price) begin
        tq = bids_q[0].qty < asks_q[0].qty ? bids_q[0].qty : asks_q[0].qty;
        f = '0;
        f.kind = KindTrade; f.bid = bids_q[0].id; f.sid = asks_q[0].id;
        f.qty = tq; f.price = asks_q[0].price;
        fills_q.insert(fills_q.size(), f);
        n++;
        bids_q[0].qty -= tq;
        asks_q[0].qty -= tq;
        if (bids_q[0].qty == 0) void'(bids_q.pop_front());
        if (asks_q[0].qty == 0) void'(asks_q.pop_front());
      end
    end
    if (n > 0) fills_q[fills_q.size()-1].last = 1'b1;
  endfunction

  // Driver: bursts with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0; s_data <= '0; s_user <= 1'b0; s_last <= 1'b0;
      burst_left <= 0; gap_left <= 0;
    end else begin
      if (s_valid && s_ready) book_order(pending_q.pop_front());
      if (!s_valid || s_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          s_valid <= 1'b1;
          s_data  <= {pending_q[0].qty, pending_q[0].price, pending_q[0].id};
          s_user  <= pending_q[0].side;
          s_last  <= pending_q[0].eob;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(12, 1);
            gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
          end else burst_left <= burst_left - 1;
        end else s_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0; errors <= 0; idle_cycles <= 0;
    end else begin
      m_ready <= ($urandom_range(63, 0) < 32) ? 1'b1 : ($urandom_range(3, 0) != 0);
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (m_valid && m_ready) begin
        if (fills_q.size() == 0) begin
          if (errors < 10) $display("unexpected result %h kind %b", m_data, m_user);
          errors <= errors + 1;
        end else begin
          if (fills_q[0].kind !== m_user || fills_q[0].bid !== m_data[31:0] ||
              fills_q[0].sid !== m_data[63:32] || fills_q[0].qty !== m_data[79:64] ||
              fills_q[0].price !== m_data[95:80] || fills_q[0].last !== m_last) begin
            if (errors < 10)
              $display("mismatch: exp kind %b b %h s %h q %h p %h l %b, got %b %h %h %h %h %b",
                       fills_q[0].kind, fills_q[0].bid, fills_q[0].sid, fills_q[0].qty,
                       fills_q[0].price, fills_q[0].last, m_user, m_data[31:0],
                       m_data[63:32], m_data[79:64], m_data[95:80], m_last);
            errors <= errors + 1;
          end
          void'(fills_q.pop_front());
        end
      end
    end
  end

  function automatic order_t mk(logic [31:0] id, logic side, logic [15:0] price,
                                logic [15:0] qty, logic eob);
    order_t o;
    o.id = id; o.side = side; o.price = price; o.qty = qty; o.eob = eob;
    return o;
  endfunction

  function automatic void enqueue(order_t o);
    pending_q.insert(pending_q.size(), o);
  endfunction

  initial begin
    order_t o;
    int     base;
    rst_ni = 1'b0;
    s_valid = 1'b0; s_data = '0; s_user = 1'b0; s_last = 1'b0; m_ready = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: extremes, zero quantity, ties at one price, partial and full fills.
    enqueue(mk(32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0));
    enqueue(mk(32'h0, 1'b0, 16'h0, 16'h0, 1'b1));
    enqueue(mk(32'h11, 1'b0, 16'h0, 16'h1, 1'b1));
    enqueue(mk(32'h12, 1'b1, 16'h5, 16'h0, 1'b1));
    enqueue(mk(32'h20, 1'b0, 16'd100, 16'd10, 1'b0));
    enqueue(mk(32'h21, 1'b0, 16'd100, 16'd10, 1'b0));
    enqueue(mk(32'h22, 1'b0, 16'd99, 16'd5, 1'b0));
    enqueue(mk(32'h23, 1'b1, 16'd98, 16'd7, 1'b1));
    enqueue(mk(32'h24, 1'b1, 16'd100, 16'hFFFF, 1'b1));
    enqueue(mk(32'h25, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1));
    // Fill the sell side, overflow it with a rejection, then end the batch with a buy.
    for (int i = 0; i < Depth; i++)
      enqueue(mk(32'h100 + i, 1'b0, 16'hFFF0 - i[15:0], 16'd3, 1'b0));
    enqueue(mk(32'h1FF, 1'b0, 16'd1, 16'd1, 1'b0));
    enqueue(mk(32'h200, 1'b1, 16'hFFFF, 16'd200, 1'b1));
    // Random: mostly prices near a midpoint so books cross often.
    for (int i = 0; i < 205; i++) begin
      base = 1000;
      o.id = $urandom();
      o.side = $urandom_range(1, 0);
      o.price = ($urandom_range(15, 0) == 0) ? 16'($urandom())
                : 16'(base + $urandom_range(20, 0) - 10);
      o.qty = ($urandom_range(20, 0) == 0) ? 16'h0
              : (($urandom_range(15, 0) == 0) ? 16'($urandom()) : 16'($urandom_range(50, 1)));
      o.eob = ($urandom_range(3, 0) == 0);
      enqueue(o);
    end
    // End with a large buy at the top price that crosses every resting sell.
    enqueue(mk(32'hA5A5_5A5A, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1));
    stim_done = 1'b1;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end
      if (stim_done && pending_q.size() == 0 && !s_valid && fills_q.size() == 0) begin
        repeat (200) @(posedge clk_i);
        if (errors == 0 && fills_q.size() == 0) $display("PASS");
        else $display("FAIL");
        $finish;
      end
    end
  end

endmodule

// ===== price_time_order_matcher.f =====
hdl/ptom_pkg.sv
hdl/ptom_ram.sv
hdl/price_time_order_matcher.sv
test/tb_price_time_order_matcher.sv
